### src/pta_pkg.sv
// Shared types and constants for the PIT time accumulator.
package pta_pkg;

  // Width of the dividend and quotient of the shared divider.
  localparam int unsigned DivWidth = 32;
  // Width of the divisor and remainder of the shared divider.
  localparam int unsigned DvsWidth = 16;

  // Shortest timeout: one interrupt every 1/(4*1000) s.
  localparam logic [31:0] MinTimeoutUs = 32'(1000 * 1000 / (4 * 1000));
  // Microseconds per millisecond, used by both conversions.
  localparam logic [15:0] UsPerMs = 16'd1000;

  // Configuration register indexes.
  localparam logic CfgTicksPerMs  = 1'b0;
  localparam logic CfgMaxTimeout  = 1'b1;

  // Item kinds carried on the input tuser.
  typedef enum logic {
    CMD_SCHEDULE = 1'b0,
    CMD_READ     = 1'b1
  } cmd_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV_START,
    S_DIV_WAIT,
    S_OUT
  } state_e;

  // Request to the shared divider.
  typedef struct packed {
    logic                start;
    logic [DivWidth-1:0] dividend;
    logic [DvsWidth-1:0] divisor;
  } div_req_t;

  // Answer from the shared divider.
  typedef struct packed {
    logic                done;
    logic [DivWidth-1:0] quotient;
  } div_rsp_t;

endpackage

### src/pta_div.sv
// Shared restoring divider that produces one quotient bit per cycle.
module pta_div
  import pta_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CntWidth = $clog2(DivWidth);
  localparam logic [CntWidth-1:0] LastStep = CntWidth'(DivWidth - 1);

  logic                busy_q, busy_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic [DvsWidth-1:0] rem_q, rem_d;
  logic [DivWidth-1:0] quo_q, quo_d;
  logic [DvsWidth-1:0] dvs_q, dvs_d;

  logic [DvsWidth:0]   shifted;
  logic [DvsWidth+1:0] trial;
  logic                fits;

  // One trial subtraction of the divisor from the shifted remainder.
  assign shifted = {rem_q, quo_q[DivWidth-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_q};
  assign fits    = ~trial[DvsWidth+1];

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      // The remainder stays below the divisor, so its low bits are enough.
      rem_d = fits ? trial[DvsWidth-1:0] : shifted[DvsWidth-1:0];
      quo_d = {quo_q[DivWidth-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand registers need no reset.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  // The quotient is complete in the cycle after the last step.
  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && !req_i.start && (cnt_q == LastStep);
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

### src/pit_time_accumulator.sv
// Top level of the PIT time accumulator: sequencer, state and shared multiplier.
// A schedule or interrupt-context read passes through the multiply, the divider start, the
// restoring divider steps, the divider's done strobe and the output state, in that order.
// A read outside interrupt context goes straight to the output state; an interrupt-context
// read with a zero tick rate skips the divider and goes from the multiply to the output.
// One item is in work at a time; rst_ni clears the time, reference count and wrap mark.
module pit_time_accumulator
  import pta_pkg::*;
#(
  parameter int unsigned CounterMax = 65535
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  // Input stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [55:0] s_axis_tdata_i,  // timeout_us, counter_value, wrapped, in_irq_context
  input  logic        s_axis_tuser_i,  // command
  // Output stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [87:0] m_axis_tdata_o,  // reload_value, signal_now, ack_irq, time_us,
                                       // multi_wrap_warning
  output logic        m_axis_tuser_o   // reload_valid
);

  localparam logic [31:0] CntMaxW  = 32'(CounterMax);
  localparam logic [16:0] CntMax17 = 17'(CounterMax);

  // Input field views.
  logic [31:0] in_duration;
  logic [15:0] in_counter;
  logic        in_wrapped;
  logic        in_irq;
  cmd_e        in_cmd;

  assign in_duration = s_axis_tdata_i[31:0];
  assign in_counter  = s_axis_tdata_i[47:32];
  assign in_wrapped  = s_axis_tdata_i[48];
  assign in_irq      = s_axis_tdata_i[49];
  assign in_cmd      = cmd_e'(s_axis_tuser_i);

  // Configuration registers.
  logic [15:0] tpm_q;
  logic [15:0] max_to_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpm_q    <= 16'd1193;
      max_to_q <= 16'd54000;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgTicksPerMs: tpm_q    <= cfg_wdata_i;
        CfgMaxTimeout: max_to_q <= cfg_wdata_i;
        default:       tpm_q    <= tpm_q;
      endcase
    end
  end

  // Architectural state.
  state_e      state_q, state_d;
  logic [15:0] ref_q;
  logic        wrap_handled_q;
  logic [63:0] elapsed_q;

  // Per-item work registers.
  cmd_e        cmd_q;
  logic [16:0] mul_a_q;
  logic [15:0] mul_b_q;
  logic [31:0] prod_q;
  logic [15:0] reload_q;
  logic        signal_q;
  logic        ack_q;
  logic        warn_q;

  // Sequencer outputs.
  logic        accept;
  logic        div_start;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  // Shared multiplier.
  logic [32:0] product;
  assign product = {16'b0, mul_a_q} * {17'b0, mul_b_q};

  // Timeout clamping for a schedule.
  logic [31:0] dur_min;
  logic [15:0] dur_clamped;

  always_comb begin
    dur_min = (in_duration < MinTimeoutUs) ? MinTimeoutUs : in_duration;
    if (in_duration == '0) begin
      dur_clamped = max_to_q;
    end else if (dur_min > {16'b0, max_to_q}) begin
      dur_clamped = max_to_q;
    end else begin
      dur_clamped = dur_min[15:0];
    end
  end

  // Wrap case selection and elapsed ticks for an interrupt-context read.
  logic        one_wrap;
  logic        multi_wrap;
  logic        mark_wrap;
  logic [16:0] tick_base;
  logic [16:0] ticks;

  always_comb begin
    one_wrap   = 1'b0;
    multi_wrap = 1'b0;
    mark_wrap  = 1'b0;
    if (!in_wrapped) begin
      one_wrap = 1'b0;
    end else if (!wrap_handled_q) begin
      one_wrap  = 1'b1;
      mark_wrap = 1'b1;
    end else if (ref_q >= in_counter) begin
      one_wrap = 1'b0;
    end else begin
      one_wrap   = 1'b1;
      multi_wrap = 1'b1;
    end
    tick_base = one_wrap ? ({1'b0, ref_q} + CntMax17) : {1'b0, ref_q};
    ticks     = (tick_base >= {1'b0, in_counter}) ? (tick_base - {1'b0, in_counter}) : '0;
  end

  // Saturated reload value from the quotient.
  logic [15:0] reload_sat;
  assign reload_sat = (div_rsp.quotient > CntMaxW) ? CntMaxW[15:0] : div_rsp.quotient[15:0];

  // Next state and handshake.
  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;
    div_start       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          if (in_cmd == CMD_READ && !in_irq) begin
            state_d = S_OUT;
          end else begin
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        // A zero tick rate adds nothing, so the divide is skipped.
        if (cmd_q == CMD_READ && tpm_q == '0) begin
          state_d = S_OUT;
        end else begin
          state_d = S_DIV_START;
        end
      end
      S_DIV_START: begin
        div_start = 1'b1;
        state_d   = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        m_axis_tvalid_o = 1'b1;
        if (m_axis_tready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Reference count, wrap mark and accumulated time.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q          <= '0;
      wrap_handled_q <= 1'b0;
      elapsed_q      <= '0;
    end else begin
      if (accept) begin
        if (in_cmd == CMD_SCHEDULE) begin
          wrap_handled_q <= 1'b0;
        end else if (in_irq) begin
          ref_q <= in_counter;
          if (mark_wrap) begin
            wrap_handled_q <= 1'b1;
          end
        end
      end
      if (state_q == S_DIV_WAIT && div_rsp.done) begin
        if (cmd_q == CMD_SCHEDULE) begin
          ref_q <= reload_sat;
        end else begin
          elapsed_q <= elapsed_q + {32'b0, div_rsp.quotient};
        end
      end
    end
  end

  // Operands and result fields of the item in work.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= in_cmd;
      reload_q <= '0;
      if (in_cmd == CMD_SCHEDULE) begin
        mul_a_q  <= {1'b0, tpm_q};
        mul_b_q  <= dur_clamped;
        signal_q <= (in_duration == '0);
        ack_q    <= (in_duration != '0);
        warn_q   <= 1'b0;
      end else begin
        mul_a_q  <= ticks;
        mul_b_q  <= UsPerMs;
        signal_q <= 1'b0;
        ack_q    <= 1'b0;
        warn_q   <= in_irq && multi_wrap;
      end
    end
    if (state_q == S_MUL) begin
      prod_q <= product[31:0];
    end
    if (state_q == S_DIV_WAIT && div_rsp.done && cmd_q == CMD_SCHEDULE) begin
      reload_q <= reload_sat;
    end
  end

  // Divider request: by 1000 for a schedule, by the tick rate for a read.
  assign div_req.start    = div_start;
  assign div_req.dividend = prod_q;
  assign div_req.divisor  = (cmd_q == CMD_SCHEDULE) ? UsPerMs : tpm_q;

  pta_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Result packing.
  assign m_axis_tuser_o = (cmd_q == CMD_SCHEDULE);
  assign m_axis_tdata_o = {5'b0, warn_q, elapsed_q, ack_q, signal_q, reload_q};

`ifndef NO_ASSERTIONS
  // Only one item is in work: no input transfer while a result is offered.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !m_axis_tvalid_o)
    else $error("input ready while a result is pending");

  // The divider only finishes while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV_WAIT))
    else $error("divider finished outside its wait state");

  // A reload value never exceeds the counter maximum.
  a_reload_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ({16'b0, reload_q} <= CntMaxW))
    else $error("reload value above counter maximum");

  // A schedule result leaves the wrap mark cleared.
  a_wrap_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> !wrap_handled_q)
    else $error("wrap mark set after a schedule");
`endif

endmodule
